// File: hdl/glh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glh_pkg
// Shared types and codes of the gray-level histogram: result status codes,
// operation codes, register map and the controller/datapath interface.
// ----------------------------------------------------------------------------
package glh_pkg;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PIX_DROP  = 2'd1,
    ST_BIN_RANGE = 2'd2
  } status_e;

  // input operation
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // register map, index taken from paddr[2]
  localparam logic       REG_MAX_LEVEL = 1'b0;
  localparam logic [7:0] MAX_LEVEL_RST = 8'd255;

  // controller to datapath
  typedef struct packed {
    logic clear;    // write zero at the sweep address and step it
    logic capture;  // latch the incoming item and read its bin
    logic commit;   // write the bin back and load the result register
  } glh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } glh_stat_t;

endpackage
`default_nettype wire

// File: hdl/gray_level_histogram_top.sv
`default_nettype none
// result: the bin is read at the input transfer; write back and result load follow in the run state,
// once the result register is free
// a new item is accepted only after the write back of the one before, on the single bin memory
// a waiting result does not block acceptance of the next item; it stalls only at write back
// reset: a clearing sweep zeroes every bin of the memory, input ready stays low
// meanwhile; max_level resets to 255 and configuration writes are taken at all times
// ----------------------------------------------------------------------------
// gray_level_histogram_top
// Gray-level histogram: counts pixels per bin, reads and clears bins on
// request, with saturating counters and range checking against max_level.
// ----------------------------------------------------------------------------
module gray_level_histogram_top #(
  parameter int unsigned LEVELS      = 256,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   op_i,
  input  wire logic [7:0]             pixel_i,
  input  wire logic [7:0]             bin_index_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [1:0]             status_o,
  output logic      [7:0]             level_o,
  output logic      [COUNT_WIDTH-1:0] count_o,
  output logic                        last_bin_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  glh_pkg::glh_cmd_t  cmd;
  glh_pkg::glh_stat_t stat;
  logic [7:0]         max_level;

  glh_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_level_o (max_level)
  );

  glh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  glh_dpath #(
    .LEVELS      (LEVELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .max_level_i (max_level),
    .op_i        (op_i),
    .pixel_i     (pixel_i),
    .bin_index_i (bin_index_i),
    .status_o    (status_o),
    .level_o     (level_o),
    .count_o     (count_o),
    .last_bin_o  (last_bin_o)
  );

endmodule
`default_nettype wire

// File: hdl/glh_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glh_regs
// APB-style configuration register: holds the largest gray level in use.
// ----------------------------------------------------------------------------
module glh_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  max_level_o
);

  logic [7:0] max_level_q, max_level_d;
  logic       wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    max_level_d = max_level_q;
    if (wr_en && (paddr[2] == glh_pkg::REG_MAX_LEVEL)) begin
      max_level_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= glh_pkg::MAX_LEVEL_RST;
    end else begin
      max_level_q <= max_level_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == glh_pkg::REG_MAX_LEVEL) begin
      prdata = {24'd0, max_level_q};
    end
  end

  assign max_level_o = max_level_q;

endmodule
`default_nettype wire

// File: hdl/glh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glh_ctrl
// Sequencer: clearing sweep after reset, then capture / commit per item with
// the result register handshake.
// ----------------------------------------------------------------------------
module glh_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output glh_pkg::glh_cmd_t        cmd_o,
  input  wire glh_pkg::glh_stat_t  stat_i
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.clear   = (state_q == S_CLEAR);
    cmd_o.capture = (state_q == S_IDLE) & in_valid_i & in_ready_q;
    cmd_o.commit  = (state_q == S_RUN) & (!out_valid_q | out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (stat_i.clear_done) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_o.capture) begin
            state_q    <= S_RUN;
            in_ready_q <= 1'b0;
          end
        end
        S_RUN: begin
          // bin data is ready, wait for a free result slot
          if (cmd_o.commit) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_CLEAR;
          in_ready_q <= 1'b0;
        end
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> (state_q == S_IDLE))
    else $error("input ready outside idle");

  a_capture_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_RUN))
    else $error("capture not followed by run");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RUN))
    else $error("result appeared without a commit");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!out_valid_q && !in_ready_q))
    else $error("handshake active during clearing sweep");
`endif

endmodule
`default_nettype wire

// File: hdl/glh_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glh_dpath
// Bin counter memory with clearing sweep, item latch, read-modify-write and
// result register.
// ----------------------------------------------------------------------------
module glh_dpath #(
  parameter int unsigned LEVELS      = 256,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire glh_pkg::glh_cmd_t       cmd_i,
  output glh_pkg::glh_stat_t           stat_o,
  input  wire logic [7:0]              max_level_i,
  input  wire logic                    op_i,
  input  wire logic [7:0]              pixel_i,
  input  wire logic [7:0]              bin_index_i,
  output logic      [1:0]              status_o,
  output logic      [7:0]              level_o,
  output logic      [COUNT_WIDTH-1:0]  count_o,
  output logic                         last_bin_o
);

  localparam int unsigned ADDR_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned EXT_W   = (ADDR_W > 8) ? ADDR_W : 8;
  localparam int unsigned TOP_LIM = (LEVELS - 1 > 255) ? 255 : LEVELS - 1;
  localparam logic [7:0]  TOP_CAP = 8'(TOP_LIM);

  logic [COUNT_WIDTH-1:0] mem [LEVELS];

  logic [ADDR_W-1:0]      clr_cnt_q;
  logic [7:0]             top_lvl;
  logic [7:0]             in_lvl;
  logic [EXT_W-1:0]       in_lvl_ext;
  logic [ADDR_W-1:0]      in_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic                   op_q;
  logic [7:0]             lvl_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   in_range_q;
  logic                   last_q;

  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] inc_val;

  logic [1:0]             res_status_q;
  logic [7:0]             res_level_q;
  logic [COUNT_WIDTH-1:0] res_count_q;
  logic                   res_last_q;
  glh_pkg::status_e       status_n;

  assign top_lvl    = (max_level_i > TOP_CAP) ? TOP_CAP : max_level_i;
  assign in_lvl     = (op_i == glh_pkg::OP_READ) ? bin_index_i : pixel_i;
  assign in_lvl_ext = EXT_W'(in_lvl);
  // truncation only matters for levels that fail the range check
  assign in_addr    = in_lvl_ext[ADDR_W-1:0];
  assign rd_addr    = cmd_i.capture ? in_addr : addr_q;

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign stat_o.clear_done = (clr_cnt_q == ADDR_W'(LEVELS - 1));

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_i;
      lvl_q      <= in_lvl;
      addr_q     <= in_addr;
      in_range_q <= (in_lvl <= top_lvl);
      last_q     <= (op_i == glh_pkg::OP_READ) & (in_lvl == top_lvl);
    end
  end

  // read-modify-write of the bin
  assign inc_val = (rdata_q == {COUNT_WIDTH{1'b1}}) ? rdata_q : rdata_q + 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = '0;
    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
    end else if (cmd_i.commit && in_range_q) begin
      wr_en   = 1'b1;
      wr_data = (op_q == glh_pkg::OP_READ) ? '0 : inc_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    status_n = glh_pkg::ST_OK;
    if (!in_range_q) begin
      status_n = (op_q == glh_pkg::OP_READ) ? glh_pkg::ST_BIN_RANGE : glh_pkg::ST_PIX_DROP;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q <= status_n;
      res_level_q  <= lvl_q;
      res_count_q  <= (in_range_q && (op_q == glh_pkg::OP_READ)) ? rdata_q : '0;
      res_last_q   <= in_range_q & last_q;
    end
  end

  assign status_o   = res_status_q;
  assign level_o    = res_level_q;
  assign count_o    = res_count_q;
  assign last_bin_o = res_last_q;

endmodule
`default_nettype wire
